FILE: sv/two_body_kinematic_curve_point_defines.svh
// Assertion macros for the two-body kinematic curve point block.
// Used by the top level only; relies on i_clk and i_rst_n in scope.
`ifndef TWO_BODY_KINEMATIC_CURVE_POINT_DEFINES_SVH
`define TWO_BODY_KINEMATIC_CURVE_POINT_DEFINES_SVH

// same-cycle implication
`define TBK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TBK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/tbk_pkg.sv
// Shared types and constants for the two-body kinematic curve point block.
// No dependencies.
package tbk_pkg;

    typedef struct packed {
        logic [11:0] point_index;
        logic        restart;
    } t_in_item;

    typedef struct packed {
        logic [23:0] angle_deg;
        logic [31:0] light_energy;
        logic        point_valid;
    } t_out_item;

    localparam logic [1:0] OP_MUL  = 2'd0;
    localparam logic [1:0] OP_DIV  = 2'd1;
    localparam logic [1:0] OP_SQRT = 2'd2;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
        logic [7:0] nbits;
    } t_unit_cmd;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    localparam logic [2:0] REG_BEAM_ENERGY  = 3'd0;
    localparam logic [2:0] REG_BEAM_MASS    = 3'd1;
    localparam logic [2:0] REG_TARGET_MASS  = 3'd2;
    localparam logic [2:0] REG_HEAVY_MASS   = 3'd3;
    localparam logic [2:0] REG_LIGHT_MASS   = 3'd4;
    localparam logic [2:0] REG_EXCITATION   = 3'd5;
    localparam logic [2:0] REG_NUM_POINTS   = 3'd6;

    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [30:0] ONE_Q30     = 31'd1073741824;
    localparam logic [7:0]  ANGLE_SCALE = 8'd180;

    // the reciprocals below are exact floors for dividends under 2^34
    localparam int RECIP_SHIFT = 42;

    // ceil(2^42 / ((2k-1)(2k))) for the k-th Taylor term of the cosine
    function automatic logic [41:0] tbk_term_recip(input logic [2:0] k);
        logic [41:0] v;
        case (k)
            3'd1:    v = 42'd2199023255552;
            3'd2:    v = 42'd366503875926;
            3'd3:    v = 42'd146601550371;
            3'd4:    v = 42'd78536544842;
            3'd5:    v = 42'd48867183457;
            3'd6:    v = 42'd33318534176;
            3'd7:    v = 42'd24165090721;
            default: v = 42'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/tbk_unit.sv
// Shared bit-serial arithmetic unit: multiply, restoring divide, integer root.
// Depends on tbk_pkg.
module tbk_unit import tbk_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_unit_cmd    i_cmd,
    input  logic [127:0] i_opa,
    input  logic [63:0]  i_opb,
    output t_unit_stat   o_stat,
    output logic [127:0] o_res
);

    logic         r_busy, n_busy;
    logic         r_done, n_done;
    logic [1:0]   r_op;
    logic [7:0]   r_cnt, n_cnt;
    logic [127:0] r_a;
    logic [63:0]  r_b;
    logic [127:0] r_acc, n_acc;
    logic [63:0]  r_rem, n_rem;

    logic [7:0]   w_idx;
    logic [64:0]  w_dsh;
    logic [65:0]  w_ssh, w_trial;

    assign w_idx   = r_cnt - 8'd1;
    assign w_dsh   = {r_rem, r_a[w_idx[6:0]]};
    assign w_ssh   = {r_rem, r_a[{w_idx[5:0], 1'b0} +: 2]};
    assign w_trial = {r_acc[63:0], 2'b01};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_rem  = r_rem;
        if (r_busy) begin
            n_cnt = w_idx;
            if (r_cnt == 8'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
            case (r_op)
                OP_MUL: begin
                    n_acc = {r_acc[126:0], 1'b0} + (r_b[w_idx[5:0]] ? r_a : 128'd0);
                end
                OP_DIV: begin
                    if (w_dsh >= {1'b0, r_b}) begin
                        n_rem = 64'(w_dsh - {1'b0, r_b});
                        n_acc = {r_acc[126:0], 1'b1};
                    end else begin
                        n_rem = w_dsh[63:0];
                        n_acc = {r_acc[126:0], 1'b0};
                    end
                end
                OP_SQRT: begin
                    if (w_ssh >= w_trial) begin
                        n_rem = 64'(w_ssh - w_trial);
                        n_acc = {r_acc[126:0], 1'b1};
                    end else begin
                        n_rem = w_ssh[63:0];
                        n_acc = {r_acc[126:0], 1'b0};
                    end
                end
                default: n_acc = r_acc;
            endcase
        end else if (i_cmd.start) begin
            n_busy = 1'b1;
            n_cnt  = i_cmd.nbits;
            n_acc  = '0;
            n_rem  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_rem <= n_rem;
        if (!r_busy && i_cmd.start) begin
            r_op <= i_cmd.op;
            r_a  <= i_opa;
            r_b  <= i_opb;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_res       = r_acc;

endmodule

FILE: sv/two_body_kinematic_curve_point.sv
// Top level of the two-body kinematic curve point block: registers and sequencer.
// Depends on tbk_pkg, tbk_unit and two_body_kinematic_curve_point_defines.svh.
//
// One curve point at a time, paced by the single bit-serial unit that does
// every multiply (one bit of the multiplier a cycle), divide (one quotient bit
// a cycle) and square root (one root bit a cycle), each in turn, about 30
// operations per point; the seven-term cosine series does its constant
// divisors as multiplies by reciprocals. A point past the curve goes straight
// to the output, and a point of a stopped curve computes only its angle. The
// input is not ready from acceptance until the result has been taken;
// configuration writes are always accepted but belong between points, as the
// sequencer reads the registers throughout a point.
`include "two_body_kinematic_curve_point_defines.svh"
module two_body_kinematic_curve_point import tbk_pkg::*; #(
    parameter int MAX_POINTS = 4096,
    parameter int FRAC_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_OUT     = 5'd1;
    localparam logic [4:0] S_WAIT    = 5'd2;
    localparam logic [4:0] S_ANG_DIV = 5'd3;
    localparam logic [4:0] S_ANG_END = 5'd4;
    localparam logic [4:0] S_X_DIV   = 5'd5;
    localparam logic [4:0] S_X_END   = 5'd6;
    localparam logic [4:0] S_Y2      = 5'd7;
    localparam logic [4:0] S_TDIV    = 5'd8;
    localparam logic [4:0] S_TEND    = 5'd9;
    localparam logic [4:0] S_T1      = 5'd10;
    localparam logic [4:0] S_T2      = 5'd11;
    localparam logic [4:0] S_SABS    = 5'd12;
    localparam logic [4:0] S_TERM    = 5'd13;
    localparam logic [4:0] S_MBML    = 5'd14;
    localparam logic [4:0] S_RSQ     = 5'd15;
    localparam logic [4:0] S_RC      = 5'd16;
    localparam logic [4:0] S_BB      = 5'd17;
    localparam logic [4:0] S_D       = 5'd18;
    localparam logic [4:0] S_DCHK    = 5'd19;
    localparam logic [4:0] S_NM      = 5'd20;
    localparam logic [4:0] S_QDIV    = 5'd21;
    localparam logic [4:0] S_QEND    = 5'd22;
    localparam logic [4:0] S_KL      = 5'd23;

    localparam logic [16:0] MAXP = 17'(MAX_POINTS);

    // configuration
    logic [25:0] r_kb, r_ee;
    logic [31:0] r_mb, r_mt, r_mh, r_ml;
    logic [12:0] r_np;

    // sequencer
    logic [4:0]   r_st, n_st, r_ret, n_ret;
    logic         r_stopped, n_stopped;
    logic [11:0]  r_p, n_p;
    logic [12:0]  r_n, n_n;
    logic         r_cneg, n_cneg;
    logic [33:0]  r_y2, n_y2, r_t, n_t;
    logic signed [35:0] r_sum, n_sum;
    logic [2:0]   r_k, n_k;
    logic [30:0]  r_c, n_c;
    logic [127:0] r_s, n_s, r_term, n_term, r_d, n_d;
    logic [63:0]  r_bmag, n_bmag, r_nm, n_nm;
    t_out_item    r_out, n_out;

    t_unit_cmd    w_cmd;
    t_unit_stat   w_stat;
    logic [127:0] w_opa, w_res;
    logic [63:0]  w_opb;

    logic [12:0]  w_neff;
    logic [32:0]  w_ap;
    logic signed [35:0] w_qe;
    logic [34:0]  w_qe_abs;
    logic signed [33:0] w_dm;
    logic [32:0]  w_dm_abs;
    logic [127:0] w_sh, w_kl;
    logic [63:0]  w_sd;
    logic [33:0]  w_tq;

    assign w_ap     = {1'b0, r_mh} + {1'b0, r_ml};
    assign w_qe     = $signed({4'b0, r_mb}) + $signed({4'b0, r_mt}) - $signed({4'b0, r_mh})
                    - $signed({4'b0, r_ml}) - $signed({10'b0, r_ee});
    assign w_qe_abs = w_qe[35] ? 35'(-w_qe) : w_qe[34:0];
    assign w_dm     = $signed({2'b0, r_mh}) - $signed({2'b0, r_mb});
    assign w_dm_abs = w_dm[33] ? 33'(-w_dm) : w_dm[32:0];
    assign w_sh     = w_res << FRAC_BITS;
    assign w_kl     = w_res >> (3 * FRAC_BITS);
    assign w_sd     = w_res[63:0];
    // quotient of a Taylor term out of its reciprocal product
    assign w_tq     = w_res[RECIP_SHIFT +: 34];

    always_comb begin
        if (r_np == 13'd0) begin
            w_neff = 13'd1;
        end else if ({4'b0, r_np} > MAXP) begin
            w_neff = 13'(MAX_POINTS);
        end else begin
            w_neff = r_np;
        end
    end

    always_comb begin
        n_st      = r_st;
        n_ret     = r_ret;
        n_stopped = r_stopped;
        n_p       = r_p;
        n_n       = r_n;
        n_cneg    = r_cneg;
        n_y2      = r_y2;
        n_t       = r_t;
        n_sum     = r_sum;
        n_k       = r_k;
        n_c       = r_c;
        n_s       = r_s;
        n_term    = r_term;
        n_d       = r_d;
        n_bmag    = r_bmag;
        n_nm      = r_nm;
        n_out     = r_out;
        w_cmd     = '0;
        w_opa     = '0;
        w_opb     = '0;
        case (r_st)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_p = i_in_item.point_index;
                    n_n = w_neff;
                    if (i_in_item.restart) begin
                        n_stopped = 1'b0;
                    end
                    n_out = '0;
                    if ({1'b0, i_in_item.point_index} >= w_neff) begin
                        n_st = S_OUT;
                    end else begin
                        w_cmd = '{start: 1'b1, op: OP_MUL, nbits: 8'd12};
                        w_opa = 128'(ANGLE_SCALE) << FRAC_BITS;
                        w_opb = {52'b0, i_in_item.point_index};
                        n_st  = S_WAIT;
                        n_ret = S_ANG_DIV;
                    end
                end
            end
            S_WAIT: begin
                if (w_stat.done) begin
                    n_st = r_ret;
                end
            end
            S_ANG_DIV: begin
                w_cmd = '{start: 1'b1, op: OP_DIV, nbits: 8'd64};
                w_opa = w_res;
                w_opb = {51'b0, r_n};
                n_st  = S_WAIT;
                n_ret = S_ANG_END;
            end
            S_ANG_END: begin
                n_out.angle_deg = w_res[23:0];
                if (r_stopped) begin
                    n_st = S_OUT;
                end else begin
                    w_cmd = '{start: 1'b1, op: OP_MUL, nbits: 8'd12};
                    w_opa = {96'b0, PI_Q30};
                    w_opb = {52'b0, r_p};
                    n_st  = S_WAIT;
                    n_ret = S_X_DIV;
                end
            end
            S_X_DIV: begin
                w_cmd = '{start: 1'b1, op: OP_DIV, nbits: 8'd64};
                w_opa = w_res;
                w_opb = {51'b0, r_n};
                n_st  = S_WAIT;
                n_ret = S_X_END;
            end
            S_X_END: begin
                // fold the second quadrant back and carry the sign apart
                n_cneg = {r_p, 1'b0} > r_n;
                w_cmd  = '{start: 1'b1, op: OP_MUL, nbits: 8'd32};
                if (n_cneg) begin
                    w_opa = {96'b0, 32'(PI_Q30 - w_res[31:0])};
                end else begin
                    w_opa = {96'b0, w_res[31:0]};
                end
                w_opb = w_opa[63:0];
                n_st  = S_WAIT;
                n_ret = S_Y2;
            end
            S_Y2: begin
                n_y2  = w_res[63:30];
                n_t   = {3'b0, ONE_Q30};
                n_sum = $signed({5'b0, ONE_Q30});
                n_k   = 3'd1;
                w_cmd = '{start: 1'b1, op: OP_MUL, nbits: 8'd34};
                w_opa = {97'b0, ONE_Q30};
                w_opb = {30'b0, w_res[63:30]};
                n_st  = S_WAIT;
                n_ret = S_TDIV;
            end
            S_TDIV: begin
                // divide by the term's constant through its reciprocal
                w_cmd = '{start: 1'b1, op: OP_MUL, nbits: 8'd42};
                w_opa = w_res >> 30;
                w_opb = {22'b0, tbk_term_recip(r_k)};
                n_st  = S_WAIT;
                n_ret = S_TEND;
            end
            S_TEND: begin
                n_t = w_tq;
                if (r_k[0]) begin
                    n_sum = r_sum - $signed({2'b0, w_tq});
                end else begin
                    n_sum = r_sum + $signed({2'b0, w_tq});
                end
                if (r_k == 3'd7) begin
                    if (n_sum < 0) begin
                        n_c = '0;
                    end else if (n_sum > $signed({5'b0, ONE_Q30})) begin
                        n_c = ONE_Q30;
                    end else begin
                        n_c = n_sum[30:0];
                    end
                    w_cmd = '{start: 1'b1, op: OP_MUL, nbits: 8'd26};
                    w_opa = {95'b0, w_dm_abs};
                    w_opb = {38'b0, r_kb};
                    n_ret = S_T1;
                end else begin
                    n_k   = r_k + 3'd1;
                    w_cmd = '{start: 1'b1, op: OP_MUL, nbits: 8'd34};
                    w_opa = {94'b0, w_tq};
                    w_opb = {30'b0, r_y2};
                    n_ret = S_TDIV;
                end
                n_st = S_WAIT;
            end
            S_T1: begin
                n_s   = w_dm[33] ? 128'(-w_res) : w_res;
                w_cmd = '{start: 1'b1, op: OP_MUL, nbits: 8'd32};
                w_opa = {93'b0, w_qe_abs};
                w_opb = {32'b0, r_mh};
                n_st  = S_WAIT;
                n_ret = S_T2;
            end
            S_T2: begin
                n_s  = r_s + (w_qe[35] ? 128'(-w_res) : w_res);
                n_st = S_SABS;
            end
            S_SABS: begin
                w_cmd = '{start: 1'b1, op: OP_MUL, nbits: 8'd33};
                w_opa = r_s[127] ? 128'(-r_s) : r_s;
                w_opb = {31'b0, w_ap};
                n_st  = S_WAIT;
                n_ret = S_TERM;
            end
            S_TERM: begin
                n_term = r_s[127] ? 128'(-w_sh) : w_sh;
                w_cmd  = '{start: 1'b1, op: OP_MUL, nbits: 8'd32};
                w_opa  = {96'b0, r_mb};
                w_opb  = {32'b0, r_ml};
                n_st   = S_WAIT;
                n_ret  = S_MBML;
            end
            S_MBML: begin
                w_cmd = '{start: 1'b1, op: OP_MUL, nbits: 8'd26};
                w_opa = {64'b0, w_res[63:0]};
                w_opb = {38'b0, r_kb};
                n_st  = S_WAIT;
                n_ret = S_RSQ;
            end
            S_RSQ: begin
                w_cmd = '{start: 1'b1, op: OP_SQRT, nbits: 8'd64};
                w_opa = w_sh;
                n_st  = S_WAIT;
                n_ret = S_RC;
            end
            S_RC: begin
                w_cmd = '{start: 1'b1, op: OP_MUL, nbits: 8'd31};
                w_opa = {64'b0, w_res[63:0]};
                w_opb = {33'b0, r_c};
                n_st  = S_WAIT;
                n_ret = S_BB;
            end
            S_BB: begin
                n_bmag = w_res[93:30];
                w_cmd  = '{start: 1'b1, op: OP_MUL, nbits: 8'd64};
                w_opa  = {64'b0, w_res[93:30]};
                w_opb  = w_res[93:30];
                n_st   = S_WAIT;
                n_ret  = S_D;
            end
            S_D: begin
                n_d  = w_res + r_term;
                n_st = S_DCHK;
            end
            S_DCHK: begin
                // no real root, or a zero sum of the outgoing masses: stop the curve
                if (w_ap == 33'd0 || r_d[127]) begin
                    n_stopped = 1'b1;
                    n_st      = S_OUT;
                end else begin
                    w_cmd = '{start: 1'b1, op: OP_SQRT, nbits: 8'd64};
                    w_opa = r_d;
                    n_st  = S_WAIT;
                    n_ret = S_NM;
                end
            end
            S_NM: begin
                if (!r_cneg) begin
                    n_nm = w_sd + r_bmag;
                end else if (w_sd >= r_bmag) begin
                    n_nm = w_sd - r_bmag;
                end else begin
                    n_nm = r_bmag - w_sd;
                end
                n_st = S_QDIV;
            end
            S_QDIV: begin
                w_cmd = '{start: 1'b1, op: OP_DIV, nbits: 8'd128};
                w_opa = {64'b0, r_nm} << FRAC_BITS;
                w_opb = {31'b0, w_ap};
                n_st  = S_WAIT;
                n_ret = S_QEND;
            end
            S_QEND: begin
                n_out.point_valid = 1'b1;
                if (|w_res[127:63]) begin
                    n_out.light_energy = '1;
                    n_st = S_OUT;
                end else begin
                    w_cmd = '{start: 1'b1, op: OP_MUL, nbits: 8'd64};
                    w_opa = w_res;
                    w_opb = w_res[63:0];
                    n_st  = S_WAIT;
                    n_ret = S_KL;
                end
            end
            S_KL: begin
                n_out.light_energy = (|w_kl[127:32]) ? 32'hFFFF_FFFF : w_kl[31:0];
                n_st = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= S_IDLE;
            r_ret     <= S_IDLE;
            r_stopped <= 1'b0;
            r_kb      <= '0;
            r_mb      <= 32'd65536;
            r_mt      <= 32'd65536;
            r_mh      <= 32'd65536;
            r_ml      <= 32'd65536;
            r_ee      <= '0;
            r_np      <= 13'd4096;
        end else begin
            r_st      <= n_st;
            r_ret     <= n_ret;
            r_stopped <= n_stopped;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_BEAM_ENERGY: r_kb <= i_cfg_data[25:0];
                    REG_BEAM_MASS:   r_mb <= i_cfg_data;
                    REG_TARGET_MASS: r_mt <= i_cfg_data;
                    REG_HEAVY_MASS:  r_mh <= i_cfg_data;
                    REG_LIGHT_MASS:  r_ml <= i_cfg_data;
                    REG_EXCITATION:  r_ee <= i_cfg_data[25:0];
                    REG_NUM_POINTS:  r_np <= i_cfg_data[12:0];
                    default:         r_np <= r_np;
                endcase
            end
        end
        r_p    <= n_p;
        r_n    <= n_n;
        r_cneg <= n_cneg;
        r_y2   <= n_y2;
        r_t    <= n_t;
        r_sum  <= n_sum;
        r_k    <= n_k;
        r_c    <= n_c;
        r_s    <= n_s;
        r_term <= n_term;
        r_d    <= n_d;
        r_bmag <= n_bmag;
        r_nm   <= n_nm;
        r_out  <= n_out;
    end

    tbk_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_opa   (w_opa),
        .i_opb   (w_opb),
        .o_stat  (w_stat),
        .o_res   (w_res)
    );

    assign o_in_ready  = (r_st == S_IDLE);
    assign o_out_valid = (r_st == S_OUT);
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    `TBK_ASSERT_NOW(a_start_idle_unit, w_cmd.start, !w_stat.busy, "unit started while busy")
    `TBK_ASSERT_NEXT(a_start_busy, w_cmd.start, w_stat.busy, "unit did not take its command")
    `TBK_ASSERT_NEXT(a_accept_blocks, i_in_valid && o_in_ready, !o_in_ready, "input taken twice")
    `TBK_ASSERT_NOW(a_done_waiting, w_stat.done, r_st == S_WAIT, "unit result not awaited")

endmodule
